// ===== design/sfb_pkg.sv =====
// Shared types and constants of the scrolling frame buffer.
package sfb_pkg;

  localparam int OP_W       = 3;
  localparam int COORD_W    = 6;
  localparam int VALUE_W    = 32;
  localparam int SIZE_W     = 7;
  localparam int DIV_W      = SIZE_W + 1;
  localparam int CNT_W      = 4;
  localparam int CFG_DATA_W = 32;
  localparam int PADDR_W    = 3;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(16);
  localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_READ        = 3'd0,
    OP_WRITE       = 3'd1,
    OP_PUSH_RIGHT  = 3'd2,
    OP_PUSH_LEFT   = 3'd3,
    OP_PUSH_BOTTOM = 3'd4,
    OP_PUSH_TOP    = 3'd5
  } op_e;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD_COFF,
    ST_MOD_PX,
    ST_MOD_ROFF,
    ST_MOD_PY,
    ST_ADDR,
    ST_MEM,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] remainder;
  } mod_rsp_t;

endpackage

// ===== design/sfb_in_if.sv =====
// Request channel of the scrolling frame buffer.
interface sfb_in_if import sfb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output operation, output col, output row, output value,
                  input ready);
  modport sink (input valid, input operation, input col, input row, input value,
                output ready);
endinterface

// ===== design/sfb_out_if.sv =====
// Result channel of the scrolling frame buffer.
interface sfb_out_if import sfb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink (input valid, input read_data, output ready);
endinterface

// ===== design/scrolling_frame_buffer_unit.sv =====
// Scrolling frame buffer: circular pixel store with column and row scroll offsets.
//
// Usage. Requests arrive on in_i (operation, col, row, value) and are taken when valid
// and ready are both high. Each request yields exactly one result on out_o: the pixel
// word for a read, zero for writes, pushes and unknown operation codes. The width and
// height in use are written at byte addresses 0 and 4 of the APB-style port (pready is
// always high), by the user only while the block is idle; the block does not enforce it.
//
// Timing. After the accepting edge a request runs four remainder passes in turn
// through the shared bit-serial unit (column offset, column, row offset, row),
// then forms the address (ST_ADDR), accesses the store (ST_MEM) and hands the result
// over (ST_RESP). A new request is taken only once the current one has finished and
// its result has been loaded into the output register.
//
// Reset. After reset the block sweeps the whole store with zeros, one word a cycle,
// MAX_WIDTH*MAX_HEIGHT words (4096 with the default sizes); in_i.ready
// stays low until the sweep has finished. Register writes are taken throughout.
//
// Stalls. The result sits in an output register. When the receiver holds ready low,
// the block finishes its current request and then waits with in_i.ready low until
// that register is free.
module scrolling_frame_buffer_unit import sfb_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int PIXEL_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sfb_in_if.sink                in_i,
  sfb_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t     cfg;
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  state_e state_q, state_d;

  // Captured request.
  op_e                op_q;
  logic [COORD_W-1:0] col_q;
  logic [COORD_W-1:0] row_q;
  logic [VALUE_W-1:0] val_q;

  // Reduced offsets and physical coordinates of the current request.
  logic [SIZE_W-1:0] c_q;
  logic [SIZE_W-1:0] r_q;
  logic [SIZE_W-1:0] px_q;
  logic [SIZE_W-1:0] py_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] clr_q;

  logic [SIZE_W-1:0] col_off_q, col_off_d;
  logic [SIZE_W-1:0] row_off_q, row_off_d;

  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic [PIXEL_BITS-1:0] rd_q;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [PIXEL_BITS-1:0] mem_wdata;
  logic [63:0]           val_ext;
  logic [63:0]           rd_ext;

  logic               out_valid_q;
  logic [VALUE_W-1:0] out_data_q;
  logic               out_load;

  logic [SIZE_W-1:0] w_use;
  logic [SIZE_W-1:0] h_use;
  logic [SIZE_W-1:0] x_sel;
  logic [SIZE_W-1:0] y_sel;
  logic              is_write_op;
  logic              clear_last;

  sfb_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfb_mod_unit u_mod_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // Sizes in use: zero counts as one, anything above the store's extent is clamped.
  always_comb begin
    if (cfg.width == '0) begin
      w_use = SIZE_W'(1);
    end else if (int'(cfg.width) > MAX_WIDTH) begin
      w_use = SIZE_W'(MAX_WIDTH);
    end else begin
      w_use = cfg.width;
    end
    if (cfg.height == '0) begin
      h_use = SIZE_W'(1);
    end else if (int'(cfg.height) > MAX_HEIGHT) begin
      h_use = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_use = cfg.height;
    end
  end

  // Logical coordinates touched by each operation. Pushes pin one axis to an edge.
  always_comb begin
    x_sel       = SIZE_W'(col_q);
    y_sel       = SIZE_W'(row_q);
    is_write_op = 1'b0;
    unique case (op_q)
      OP_READ: begin
      end
      OP_WRITE: begin
        is_write_op = 1'b1;
      end
      OP_PUSH_RIGHT: begin
        x_sel       = '0;
        is_write_op = 1'b1;
      end
      OP_PUSH_LEFT: begin
        x_sel       = w_use - SIZE_W'(1);
        is_write_op = 1'b1;
      end
      OP_PUSH_BOTTOM: begin
        y_sel       = '0;
        is_write_op = 1'b1;
      end
      OP_PUSH_TOP: begin
        y_sel       = h_use - SIZE_W'(1);
        is_write_op = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign clear_last = (clr_q == ADDR_W'(DEPTH - 1));
  assign out_load   = (state_q == ST_RESP) && (!out_valid_q || out_o.ready);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_MOD_COFF;
      end
      ST_MOD_COFF: begin
        if (mod_rsp.done) state_d = ST_MOD_PX;
      end
      ST_MOD_PX: begin
        if (mod_rsp.done) state_d = ST_MOD_ROFF;
      end
      ST_MOD_ROFF: begin
        if (mod_rsp.done) state_d = ST_MOD_PY;
      end
      ST_MOD_PY: begin
        if (mod_rsp.done) state_d = ST_ADDR;
      end
      ST_ADDR: begin
        state_d = ST_MEM;
      end
      ST_MEM: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs. A remainder pass is launched on entry to each reduction state;
  // the column and row passes add the offset just reduced by the previous pass.
  always_comb begin
    in_i.ready       = (state_q == ST_IDLE);
    mod_req.start    = 1'b0;
    mod_req.dividend = '0;
    mod_req.divisor  = w_use;
    mem_we           = 1'b0;
    mem_waddr        = addr_q;
    mem_wdata        = val_ext[PIXEL_BITS-1:0];
    unique case (state_d)
      ST_MOD_COFF: begin
        mod_req.dividend = DIV_W'(col_off_q);
      end
      ST_MOD_PX: begin
        mod_req.dividend = DIV_W'(x_sel) + DIV_W'(mod_rsp.remainder);
      end
      ST_MOD_ROFF: begin
        mod_req.dividend = DIV_W'(row_off_q);
        mod_req.divisor  = h_use;
      end
      ST_MOD_PY: begin
        mod_req.dividend = DIV_W'(y_sel) + DIV_W'(mod_rsp.remainder);
        mod_req.divisor  = h_use;
      end
      default: begin
      end
    endcase
    if ((state_d == ST_MOD_COFF || state_d == ST_MOD_PX || state_d == ST_MOD_ROFF ||
         state_d == ST_MOD_PY) && (state_d != state_q)) begin
      mod_req.start = 1'b1;
    end
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == ST_MEM) begin
      mem_we = is_write_op;
    end
  end

  // Offset steps: taken only on the last element of a push, from the reduced offset.
  always_comb begin
    col_off_d = col_off_q;
    row_off_d = row_off_q;
    if (state_q == ST_ADDR) begin
      unique case (op_q)
        OP_PUSH_RIGHT: begin
          if (SIZE_W'(row_q) == h_use - SIZE_W'(1)) begin
            col_off_d = (c_q + SIZE_W'(1) == w_use) ? '0 : c_q + SIZE_W'(1);
          end
        end
        OP_PUSH_LEFT: begin
          if (SIZE_W'(row_q) == h_use - SIZE_W'(1)) begin
            col_off_d = (c_q == '0) ? w_use - SIZE_W'(1) : c_q - SIZE_W'(1);
          end
        end
        OP_PUSH_BOTTOM: begin
          if (SIZE_W'(col_q) == w_use - SIZE_W'(1)) begin
            row_off_d = (r_q + SIZE_W'(1) == h_use) ? '0 : r_q + SIZE_W'(1);
          end
        end
        OP_PUSH_TOP: begin
          if (SIZE_W'(col_q) == w_use - SIZE_W'(1)) begin
            row_off_d = (r_q == '0) ? h_use - SIZE_W'(1) : r_q - SIZE_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      col_off_q   <= '0;
      row_off_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      col_off_q <= col_off_d;
      row_off_q <= row_off_d;
      if (state_q == ST_CLEAR && !clear_last) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture and per-request working registers.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q  <= op_e'(in_i.operation);
      col_q <= in_i.col;
      row_q <= in_i.row;
      val_q <= in_i.value;
    end
    if (mod_rsp.done) begin
      unique case (state_q)
        ST_MOD_COFF: c_q  <= mod_rsp.remainder;
        ST_MOD_PX:   px_q <= mod_rsp.remainder;
        ST_MOD_ROFF: r_q  <= mod_rsp.remainder;
        ST_MOD_PY:   py_q <= mod_rsp.remainder;
        default:     ;
      endcase
    end
    if (state_q == ST_ADDR) begin
      addr_q <= ADDR_W'(int'(py_q) * MAX_WIDTH + int'(px_q));
    end
    if (out_load) begin
      out_data_q <= (op_q == OP_READ) ? rd_ext[VALUE_W-1:0] : '0;
    end
  end

  assign val_ext = 64'(val_q);
  assign rd_ext  = 64'(rd_q);

  // Pixel store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MEM) begin
      rd_q <= mem[addr_q];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_data_q;

`ifndef SYNTH
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_i.ready)
    else $error("request taken while the store is being cleared");

  a_mod_done_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> (state_q == ST_MOD_COFF || state_q == ST_MOD_PX ||
                      state_q == ST_MOD_ROFF || state_q == ST_MOD_PY))
    else $error("remainder unit finished outside a reduction pass");

  a_resp_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && out_valid_q && !out_o.ready) |=> (state_q == ST_RESP))
    else $error("result dropped while the output register was occupied");
`endif

endmodule

// ===== design/sfb_mod_unit.sv =====
// Bit-serial restoring remainder unit shared by all coordinate reductions.
module sfb_mod_unit import sfb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);

  logic [DIV_W-1:0]  a_q;
  logic [SIZE_W-1:0] m_q;
  logic [SIZE_W-1:0] rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DIV_W-1:0]  trial;
  logic [DIV_W-1:0]  rem_next;

  // While a pass is running, one dividend bit enters the partial remainder per cycle.
  assign trial = {rem_q, a_q[DIV_W-1]};

  always_comb begin
    if (trial >= {1'b0, m_q}) begin
      rem_next = trial - {1'b0, m_q};
    end else begin
      rem_next = trial;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DIV_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.dividend;
      m_q   <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      a_q   <= {a_q[DIV_W-2:0], 1'b0};
      rem_q <= rem_next[SIZE_W-1:0];
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== design/sfb_cfg_regs.sv =====
// APB-style register file holding the width and height in use.
module sfb_cfg_regs import sfb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [SIZE_W-1:0] width_q;
  logic [SIZE_W-1:0] height_q;
  logic              wr_en;
  reg_e              sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (wr_en) begin
      unique case (sel)
        REG_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_WIDTH:  prdata = CFG_DATA_W'(width_q);
      REG_HEIGHT: prdata = CFG_DATA_W'(height_q);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.width  = width_q;
  assign cfg_o.height = height_q;

endmodule
